// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package plti_pkg;
	localparam int MaxPoints = 256;
	localparam int SlotW = $clog2(MaxPoints);
	localparam int CountW = SlotW + 1;
	localparam int QDepth = 2;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  point_slot;
		logic [23:0] point_energy;
		logic [15:0] point_efficiency;
		logic [15:0] point_uncertainty;
		logic [23:0] query_energy;
		logic [31:0] func_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] interp_efficiency;
		logic [15:0] mean_uncertainty;
		logic [31:0] corrected_value;
	} result_t;

	// classified request handed from front to back
	typedef struct packed {
		logic        is_query;
		logic        miss;
		logic [7:0]  slot;
		logic [23:0] energy;
		logic [15:0] efficiency;
		logic [15:0] uncertainty;
		logic [31:0] func_value;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAST_RD, ST_LAST_CHK, ST_SCAN_RD, ST_SCAN_CHK,
		ST_HI_RD, ST_HI_CHK, ST_MUL, ST_IDIV, ST_QDIV, ST_DONE
	} back_state_t;
endpackage
`default_nettype wire

// ===== src/plti_ram.sv =====
// ----------------------------------------------------------------------------
// plti_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module plti_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/plti_front.sv =====
// ----------------------------------------------------------------------------
// plti_front
// Accepts requests, classifies them and pushes them into a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module plti_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire plti_pkg::req_t    req,
	input  wire logic [8:0]        points_in_use,
	output logic                   busy,
	output plti_pkg::job_t         job,
	output logic                   job_valid,
	input  wire logic              job_pop
);
	import plti_pkg::*;

	job_t               q_q [QDepth];
	logic [$clog2(QDepth)-1:0] wr_q, rd_q;
	logic [$clog2(QDepth):0]   cnt_q;
	logic               push;
	job_t               in_job;

	assign busy = (cnt_q == ($clog2(QDepth)+1)'(QDepth));
	assign push = start && !busy;

	always_comb begin
		in_job.is_query    = (req.req_type == REQ_QUERY);
		// fewer than two points misses at once
		in_job.miss        = (points_in_use < 9'd2);
		in_job.slot        = req.point_slot;
		in_job.energy      = (req.req_type == REQ_QUERY) ? req.query_energy
		                                                 : req.point_energy;
		in_job.efficiency  = req.point_efficiency;
		in_job.uncertainty = req.point_uncertainty;
		in_job.func_value  = req.func_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (job_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QDepth){1'b0}}, push}
			      - {{$clog2(QDepth){1'b0}}, job_pop};
		end
	end

	assign job_valid = (cnt_q != '0);
	assign job       = q_q[rd_q];

	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, job_pop, job_valid)
	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= ($clog2(QDepth)+1)'(QDepth))
	`ASSERT_NEXT(a_push_count, clk, arst_n, push && !job_pop, cnt_q != '0)
endmodule
`default_nettype wire

// ===== src/plti_back.sv =====
// ----------------------------------------------------------------------------
// plti_back
// Executes loads and queries: segment scan, interpolation and division.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module plti_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire plti_pkg::job_t    job,
	input  wire logic              job_valid,
	output logic                   job_pop,
	input  wire logic [8:0]        points_in_use,
	output logic                   done,
	output plti_pkg::result_t      result
);
	import plti_pkg::*;

	back_state_t state_q, state_d;
	logic [SlotW-1:0] raddr;
	logic [23:0] e_rd;
	logic [15:0] f_rd, u_rd;
	logic        we;
	logic [CountW-1:0] n_eff;
	logic [SlotW-1:0]  idx_q;     // upper index of current pair
	logic [23:0] e_lo_q;
	logic [15:0] f_lo_q, u_lo_q, f_hi_q, u_hi_q;
	logic [39:0] prod_q;          // offs*diff + span/2, then divided
	logic [23:0] span_q;
	logic [39:0] rem_q;
	logic [39:0] quo_q;
	logic [5:0]  bit_q;
	logic [15:0] eff_q;
	logic [47:0] num_q;
	logic [47:0] qquo_q;
	logic [16:0] qrem_q;
	logic        hit_d;
	logic [23:0] offs, span_w;
	logic [15:0] diff;
	logic [40:0] rem_sh;
	logic [17:0] qrem_sh;
	logic [16:0] mag_eff;

	assign n_eff = (points_in_use > 9'(MaxPoints)) ? CountW'(MaxPoints)
	                                               : points_in_use[CountW-1:0];
	assign we = (state_q == ST_IDLE) && job_valid && !job.is_query;

	plti_ram #(.Width(24), .Depth(MaxPoints)) u_e (.clk, .we, .waddr(job.slot),
		.wdata(job.energy), .raddr, .rdata(e_rd));
	plti_ram #(.Width(16), .Depth(MaxPoints)) u_f (.clk, .we, .waddr(job.slot),
		.wdata(job.efficiency), .raddr, .rdata(f_rd));
	plti_ram #(.Width(16), .Depth(MaxPoints)) u_u (.clk, .we, .waddr(job.slot),
		.wdata(job.uncertainty), .raddr, .rdata(u_rd));

	assign offs   = job.energy - e_lo_q;
	assign span_w = e_rd - e_lo_q;
	assign diff   = (f_hi_q >= f_lo_q) ? f_hi_q - f_lo_q : f_lo_q - f_hi_q;
	assign rem_sh = {rem_q, prod_q[39]};
	assign qrem_sh = {qrem_q, num_q[47]};
	assign mag_eff = (f_hi_q >= f_lo_q) ? {1'b0, f_lo_q} + {1'b0, quo_q[15:0]}
	                                    : {1'b0, f_lo_q} - {1'b0, quo_q[15:0]};

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		raddr   = idx_q;
		hit_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = SlotW'(n_eff - 1'b1);
				if (job_valid) begin
					if (!job.is_query) job_pop = 1'b1;
					else if (job.miss) state_d = ST_DONE;
					else state_d = ST_LAST_RD;
				end
			end
			ST_LAST_RD: begin
				raddr = SlotW'(n_eff - 1'b1);
				state_d = ST_LAST_CHK;
			end
			ST_LAST_CHK: begin
				raddr = '0;
				state_d = (job.energy > e_rd) ? ST_DONE : ST_SCAN_RD;
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				// e_rd holds entry idx_q; previous entry in e_lo_q
				hit_d = (idx_q != '0) && (job.energy >= e_lo_q) && (job.energy < e_rd);
				raddr = idx_q - 1'b1;
				if (hit_d) state_d = ST_HI_RD;
				else if ({1'b0, idx_q} == n_eff - 1'b1) state_d = ST_DONE;
				else begin
					raddr = idx_q + 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_HI_RD:  state_d = ST_HI_CHK;
			ST_HI_CHK: state_d = ST_MUL;
			ST_MUL:    state_d = ST_IDIV;
			ST_IDIV:   if (bit_q == 6'd0) state_d = ST_QDIV;
			ST_QDIV:   if (bit_q == 6'd0) state_d = ST_DONE;
			ST_DONE: begin
				job_pop = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= (state_q == ST_DONE);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
				result <= '0;
			end
			ST_SCAN_CHK: begin
				if (hit_d) begin
					span_q <= span_w;
				end else begin
					e_lo_q <= e_rd;
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_HI_RD: ;
			ST_HI_CHK: begin
				// raddr was idx-1 then idx: upper row arrives now
				f_hi_q <= f_rd;
				u_hi_q <= u_rd;
			end
			ST_MUL: begin
				prod_q <= 40'(offs * diff) + 40'(span_q >> 1);
				rem_q  <= '0;
				bit_q  <= 6'd40;
			end
			ST_IDIV: begin
				if (bit_q != 6'd0) begin
					prod_q <= {prod_q[38:0], 1'b0};
					if (rem_sh >= {17'd0, span_q}) begin
						rem_q <= 40'(rem_sh - {17'd0, span_q});
						quo_q <= {quo_q[38:0], 1'b1};
					end else begin
						rem_q <= rem_sh[39:0];
						quo_q <= {quo_q[38:0], 1'b0};
					end
					bit_q <= bit_q - 1'b1;
				end else begin
					eff_q  <= mag_eff[15:0];
					num_q  <= {job.func_value, 16'd0};
					qrem_q <= '0;
					bit_q  <= 6'd48;
				end
			end
			ST_QDIV: begin
				if (bit_q != 6'd0) begin
					num_q <= {num_q[46:0], 1'b0};
					if (qrem_sh >= {2'd0, eff_q}) begin
						qrem_q <= 17'(qrem_sh - {2'd0, eff_q});
						qquo_q <= {qquo_q[46:0], 1'b1};
					end else begin
						qrem_q <= qrem_sh[16:0];
						qquo_q <= {qquo_q[46:0], 1'b0};
					end
					bit_q <= bit_q - 1'b1;
				end else if (eff_q != '0) begin
					result.found <= 1'b1;
					result.interp_efficiency <= eff_q;
					result.mean_uncertainty <= 16'(({1'b0, u_lo_q} + {1'b0, u_hi_q}) >> 1);
					result.corrected_value <= (qquo_q[47:32] != '0) ? '1 : qquo_q[31:0];
				end
			end
			default: ;
		endcase
		// lower row of the pair arrives first
		if (state_q == ST_HI_RD) begin
			f_lo_q <= f_rd;
			u_lo_q <= u_rd;
		end
		if (state_q == ST_LAST_CHK) e_lo_q <= '0;
	end

	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`ASSERT_IMPLIES(a_found_nz, clk, arst_n, done && result.found,
		result.interp_efficiency != '0)
	`ASSERT_IMPLIES(a_no_write_busy, clk, arst_n, we, state_q == ST_IDLE)
endmodule
`default_nettype wire

// ===== src/piecewise_linear_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Table of energy/efficiency points with linear interpolation and division.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// request   | start / busy       | req (req_t)
// result    | done strobe        | result (result_t)
// config    | cfg_valid/cfg_ready| cfg_data (points_in_use)
//
// A query scans the table entry by entry through the registered RAM
// read, then runs a 40-step interpolation divider and a 48-step
// quotient divider.
// Reset clears the count and control; table contents are undefined until
// loaded. The receiver cannot stall: done pulses for one cycle.
`default_nettype none
module piecewise_linear_table_interpolator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire plti_pkg::req_t       req,
	output logic                      done,
	output plti_pkg::result_t         result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [8:0]           cfg_data
);
	import plti_pkg::*;

	logic [8:0] points_q;
	job_t       job;
	logic       job_valid, job_pop;

	assign cfg_ready = 1'b1;

	// hold the point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) points_q <= '0;
		else if (cfg_valid) points_q <= cfg_data;
	end

	plti_front u_front (.clk, .arst_n, .start, .req, .points_in_use(points_q),
		.busy, .job, .job_valid, .job_pop);

	plti_back u_back (.clk, .arst_n, .job, .job_valid, .job_pop,
		.points_in_use(points_q), .done, .result);
endmodule
`default_nettype wire
